// ===== rtl/box_plane_side_test_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the box-plane side test
// Define ASSERT_OFF to compile every check away.
// ---------------------------------------------------------------------------
`ifndef BOX_PLANE_SIDE_TEST_ASSERT_SVH
`define BOX_PLANE_SIDE_TEST_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold on every clock edge outside reset.
`define BPS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
// Expression must never be true outside reset.
`define BPS_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("forbidden condition seen");
`else
`define BPS_ASSERT(lbl, clk, rstn, prop)
`define BPS_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== rtl/bpst_pkg.sv =====
// ---------------------------------------------------------------------------
// bpst_pkg
// Shared widths and control types of the box-plane side test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpst_pkg;

	localparam int unsigned COORD_W   = 32;
	localparam int unsigned PROD_W    = 2 * COORD_W;
	localparam int unsigned SUM_W     = PROD_W + 2;
	localparam int unsigned FRAC_BITS = 16;

	// stage load strobes handed to the dot-product lanes
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} stage_ld_t;

endpackage

`default_nettype wire

// ===== rtl/bpst_dot.sv =====
// ---------------------------------------------------------------------------
// bpst_dot
// One corner lane: exact dot product against the normal, minus the scaled
// distance, reduced to a non-negative flag over three register stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpst_dot #(
	parameter int unsigned FRAC_BITS = bpst_pkg::FRAC_BITS
) (
	input  wire logic                                    clk,
	input  wire bpst_pkg::stage_ld_t                     ld,
	input  wire logic signed [bpst_pkg::COORD_W-1:0]     normal_x,
	input  wire logic signed [bpst_pkg::COORD_W-1:0]     normal_y,
	input  wire logic signed [bpst_pkg::COORD_W-1:0]     normal_z,
	input  wire logic signed [bpst_pkg::COORD_W-1:0]     plane_dist,
	input  wire logic signed [bpst_pkg::COORD_W-1:0]     corner_x,
	input  wire logic signed [bpst_pkg::COORD_W-1:0]     corner_y,
	input  wire logic signed [bpst_pkg::COORD_W-1:0]     corner_z,
	output logic                                         nonneg
);

	localparam int unsigned CW   = bpst_pkg::COORD_W;
	localparam int unsigned PW   = bpst_pkg::PROD_W;
	localparam int unsigned SW   = bpst_pkg::SUM_W;
	localparam int unsigned DW   = CW + FRAC_BITS;

	logic signed [PW-1:0] px_s2, py_s2, pz_s2;
	logic signed [CW-1:0] dist_s2;
	logic signed [SW-1:0] dsc;
	logic signed [SW-1:0] sa_s3, sb_s3;
	logic signed [SW-1:0] total;
	logic                 nonneg_s4;

	// stage 2: three exact products
	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			px_s2   <= normal_x * corner_x;
			py_s2   <= normal_y * corner_y;
			pz_s2   <= normal_z * corner_z;
			dist_s2 <= plane_dist;
		end
	end

	// distance brought to the product scale
	assign dsc = {{(SW-DW){dist_s2[CW-1]}}, dist_s2, {FRAC_BITS{1'b0}}};

	// stage 3: two partial sums
	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			sa_s3 <= {{(SW-PW){px_s2[PW-1]}}, px_s2} + {{(SW-PW){py_s2[PW-1]}}, py_s2};
			sb_s3 <= {{(SW-PW){pz_s2[PW-1]}}, pz_s2} - dsc;
		end
	end

	assign total = sa_s3 + sb_s3;

	// stage 4: sign of the full sum
	always_ff @(posedge clk) begin
		if (ld.ld_s4) begin
			nonneg_s4 <= ~total[SW-1];
		end
	end

	assign nonneg = nonneg_s4;

endmodule

`default_nettype wire

// ===== rtl/box_plane_side_test.sv =====
// An accepted input beat passes the stage 1 to stage 4 registers before its result
// shows on the master side, where it is taken while m_tready is high.
// Throughput: one beat per cycle if not stalled; each stage has its own valid bit
// and moves whenever its successor is empty or moving, so bubbles collapse under stall.
// The clock period is bounded by the stage 2 multipliers (six 32x32 products per beat).
// Reset: arst_n clears every valid bit asynchronously; the datapath is not reset.
// ---------------------------------------------------------------------------
// box_plane_side_test
// Classifies an axis-aligned box against a plane n.x = d in signed fixed
// point: bit 0 when the far corner is on or in front, bit 1 when the near
// corner is behind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "box_plane_side_test_assert.svh"

module box_plane_side_test #(
	parameter int unsigned FRAC_BITS = bpst_pkg::FRAC_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slave side
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata, lowest bit up: normal_x[31:0], normal_y[63:32], normal_z[95:64],
	// plane_dist[127:96], corner_select[130:128], box_min_x[162:131],
	// box_min_y[194:163], box_min_z[226:195], box_max_x[258:227],
	// box_max_y[290:259], box_max_z[322:291], zero pad [327:323]
	input  wire logic [327:0] s_tdata,
	// master side
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata, lowest bit up: sides[1:0], zero pad [7:2]
	output logic [7:0]        m_tdata
);

	localparam int unsigned CW = bpst_pkg::COORD_W;

	typedef logic signed [CW-1:0] coord_t;

	// unpack the input beat
	coord_t     nx, ny, nz, pdist, mnx, mny, mnz, mxx, mxy, mxz;
	logic [2:0] sel;

	assign nx    = s_tdata[31:0];
	assign ny    = s_tdata[63:32];
	assign nz    = s_tdata[95:64];
	assign pdist = s_tdata[127:96];
	assign sel   = s_tdata[130:128];
	assign mnx   = s_tdata[162:131];
	assign mny   = s_tdata[194:163];
	assign mnz   = s_tdata[226:195];
	assign mxx   = s_tdata[258:227];
	assign mxy   = s_tdata[290:259];
	assign mxz   = s_tdata[322:291];

	// valid bits and per-stage ready chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	bpst_pkg::stage_ld_t ld;

	assign rdy_s4   = !v_s4 || m_tready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// load a stage only when something valid arrives and the stage may move
	assign ld.ld_s2 = v_s1 && rdy_s2;
	assign ld.ld_s3 = v_s2 && rdy_s3;
	assign ld.ld_s4 = v_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: pick the far and near corners from the select code.
	// Bit i set: far takes min on axis i, near takes max.
	coord_t nx_s1, ny_s1, nz_s1, dist_s1;
	coord_t fx_s1, fy_s1, fz_s1, rx_s1, ry_s1, rz_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy_s1) begin
			nx_s1   <= nx;
			ny_s1   <= ny;
			nz_s1   <= nz;
			dist_s1 <= pdist;
			fx_s1   <= sel[0] ? mnx : mxx;
			fy_s1   <= sel[1] ? mny : mxy;
			fz_s1   <= sel[2] ? mnz : mxz;
			rx_s1   <= sel[0] ? mxx : mnx;
			ry_s1   <= sel[1] ? mxy : mny;
			rz_s1   <= sel[2] ? mxz : mnz;
		end
	end

	// stages 2 to 4: one lane per corner
	logic far_nonneg, near_nonneg;

	bpst_dot #(
		.FRAC_BITS(FRAC_BITS)
	) u_far (
		.clk       (clk),
		.ld        (ld),
		.normal_x  (nx_s1),
		.normal_y  (ny_s1),
		.normal_z  (nz_s1),
		.plane_dist(dist_s1),
		.corner_x  (fx_s1),
		.corner_y  (fy_s1),
		.corner_z  (fz_s1),
		.nonneg    (far_nonneg)
	);

	bpst_dot #(
		.FRAC_BITS(FRAC_BITS)
	) u_near (
		.clk       (clk),
		.ld        (ld),
		.normal_x  (nx_s1),
		.normal_y  (ny_s1),
		.normal_z  (nz_s1),
		.plane_dist(dist_s1),
		.corner_x  (rx_s1),
		.corner_y  (ry_s1),
		.corner_z  (rz_s1),
		.nonneg    (near_nonneg)
	);

	// front touched when far dot >= distance, back touched when near dot < distance
	assign m_tvalid = v_s4;
	assign m_tdata  = {6'b0, !near_nonneg, far_nonneg};

	// checks
	`BPS_ASSERT(a_accept_fills_s1, clk, arst_n, (s_tvalid && s_tready) |=> v_s1)
	`BPS_ASSERT(a_stall_only_when_full, clk, arst_n, !s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4))
	`BPS_ASSERT(a_out_from_s3, clk, arst_n, $rose(v_s4) |-> $past(v_s3))
	`BPS_NEVER(a_no_load_while_stalled, clk, arst_n, v_s4 && !m_tready && ld.ld_s4)

endmodule

`default_nettype wire

// ===== test/tb_box_plane_side_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_box_plane_side_test
// Streams box-plane beats through box_plane_side_test. Each beat's sides
// code comes from a local exact-arithmetic classifier or, for a few directed
// rows, is written straight into the table. Results are checked in order.
// Both sides idle at random.
// ---------------------------------------------------------------------------

module tb_box_plane_side_test;

	// one input beat; packed so that normal_x lands in the lowest bits of tdata
	typedef struct packed {
		logic [bpst_pkg::COORD_W-1:0] box_max_z;
		logic [bpst_pkg::COORD_W-1:0] box_max_y;
		logic [bpst_pkg::COORD_W-1:0] box_max_x;
		logic [bpst_pkg::COORD_W-1:0] box_min_z;
		logic [bpst_pkg::COORD_W-1:0] box_min_y;
		logic [bpst_pkg::COORD_W-1:0] box_min_x;
		logic [2:0]                   corner_select;
		logic [bpst_pkg::COORD_W-1:0] plane_dist;
		logic [bpst_pkg::COORD_W-1:0] normal_z;
		logic [bpst_pkg::COORD_W-1:0] normal_y;
		logic [bpst_pkg::COORD_W-1:0] normal_x;
	} box_beat_t;

	// directed row: the sides code is typed in only where `known` is set
	typedef struct packed {
		box_beat_t  beat;
		logic       known;
		logic [1:0] sides;
	} directed_row_t;

	localparam logic [1:0] SIDES_NONE  = 2'd0;
	localparam logic [1:0] SIDES_FRONT = 2'd1;
	localparam logic [1:0] SIDES_BACK  = 2'd2;
	localparam logic [1:0] SIDES_CROSS = 2'd3;

	localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN  = 32'h8000_0000;
	localparam logic [31:0] Q_ONE  = 32'h0001_0000;
	localparam logic [31:0] Q_MONE = 32'hffff_0000;
	localparam logic [31:0] Q_TWO  = 32'h0002_0000;
	localparam logic [31:0] Q_MTWO = 32'hfffe_0000;
	localparam logic [31:0] ALL1   = 32'hffff_ffff;

	localparam int RANDOM_BEATS = 600;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 12;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [327:0] s_tdata  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;

	logic [1:0]    sides_q[$];
	directed_row_t directed[$];
	int            mismatches = 0;
	int            idle_cycles = 0;

	box_plane_side_test i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Exact classification: widen everything to 68 bits so the three products
	// and the scaled distance can never overflow the sum.
	function automatic logic [1:0] classify_box(box_beat_t b);
		logic signed [67:0] nrm[3];
		logic signed [67:0] lo[3];
		logic signed [67:0] hi[3];
		logic signed [67:0] dist_wide;
		logic signed [67:0] far_dot;
		logic signed [67:0] near_dot;
		int i;
		nrm[0] = $signed(b.normal_x);
		nrm[1] = $signed(b.normal_y);
		nrm[2] = $signed(b.normal_z);
		lo[0]  = $signed(b.box_min_x);
		lo[1]  = $signed(b.box_min_y);
		lo[2]  = $signed(b.box_min_z);
		hi[0]  = $signed(b.box_max_x);
		hi[1]  = $signed(b.box_max_y);
		hi[2]  = $signed(b.box_max_z);
		dist_wide = $signed(b.plane_dist);
		dist_wide = dist_wide <<< bpst_pkg::FRAC_BITS;
		far_dot  = -dist_wide;
		near_dot = -dist_wide;
		for (i = 0; i < 3; i++) begin
			// a set select bit sends the far corner to min and the near one to max
			if (b.corner_select[i]) begin
				far_dot  += nrm[i] * lo[i];
				near_dot += nrm[i] * hi[i];
			end else begin
				far_dot  += nrm[i] * hi[i];
				near_dot += nrm[i] * lo[i];
			end
		end
		return {near_dot < 0, far_dot >= 0};
	endfunction

	function automatic box_beat_t mk_beat(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
			logic [31:0] pdist, logic [2:0] sel, logic [31:0] mnx, logic [31:0] mny,
			logic [31:0] mnz, logic [31:0] mxx, logic [31:0] mxy, logic [31:0] mxz);
		box_beat_t b;
		b.normal_x = nx;
		b.normal_y = ny;
		b.normal_z = nz;
		b.plane_dist = pdist;
		b.corner_select = sel;
		b.box_min_x = mnx;
		b.box_min_y = mny;
		b.box_min_z = mnz;
		b.box_max_x = mxx;
		b.box_max_y = mxy;
		b.box_max_z = mxz;
		return b;
	endfunction

	function automatic logic [31:0] rand_signed(int unsigned span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3: return ALL1;
			4: return Q_ONE;
			default: return $urandom;
		endcase
	endfunction

	// Mostly sane boxes against unit-scale planes, so that every sides code
	// turns up; the rest is raw noise and extreme values.
	function automatic box_beat_t random_beat();
		box_beat_t b;
		logic [31:0] nrm[3];
		logic [31:0] lo[3];
		logic [31:0] hi[3];
		logic [31:0] swap;
		logic [2:0] sel;
		int mode;
		int i;
		mode = $urandom_range(0, 9);
		for (i = 0; i < 3; i++) begin
			if (mode < 2) begin
				nrm[i] = $urandom;
				lo[i]  = $urandom;
				hi[i]  = $urandom;
			end else if (mode == 2) begin
				nrm[i] = pick_extreme();
				lo[i]  = pick_extreme();
				hi[i]  = pick_extreme();
			end else begin
				nrm[i] = rand_signed(1 << 17);
				lo[i]  = rand_signed(1 << 20);
				hi[i]  = lo[i] + $urandom_range(0, 1 << 19);
				// occasionally turn the box inside out on this axis
				if ($urandom_range(0, 19) == 0) begin
					swap  = lo[i];
					lo[i] = hi[i];
					hi[i] = swap;
				end
			end
			sel[i] = nrm[i][31];
		end
		// a select code that disagrees with the normal's signs now and then
		if (mode < 3 || $urandom_range(0, 9) == 0)
			sel = 3'($urandom_range(0, 7));
		b = mk_beat(nrm[0], nrm[1], nrm[2], 32'd0, sel, lo[0], lo[1], lo[2],
			hi[0], hi[1], hi[2]);
		if (mode < 2)
			b.plane_dist = $urandom;
		else if (mode == 2)
			b.plane_dist = pick_extreme();
		else
			b.plane_dist = rand_signed(1 << 22);
		return b;
	endfunction

	// Present one beat and hold it until the slave side takes it. With
	// `drain` set, first hold off until every pending result has come back.
	task automatic send_beat(box_beat_t b, logic [1:0] sides_exp, int gap, bit drain);
		if (drain) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (sides_q.size() != 0)
				@(posedge clk);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, b};
		// sample mid-cycle: the beat goes in at the next rising edge
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		sides_q.push_back(sides_exp);
		@(posedge clk);
	endtask

	// Directed table: trivial planes, exact touches, extremes, every select code.
	task automatic fill_directed();
		int s;
		directed.push_back('{mk_beat('0, '0, '0, '0, 3'd0, '0, '0, '0, '0, '0, '0),
			1'b1, SIDES_FRONT});
		// zero normal: only the sign of the distance matters
		directed.push_back('{mk_beat('0, '0, '0, Q_MIN, 3'd5, Q_MIN, Q_MAX, ALL1,
			Q_MAX, Q_MIN, '0), 1'b1, SIDES_FRONT});
		directed.push_back('{mk_beat('0, '0, '0, Q_MAX, 3'd2, Q_MAX, Q_MIN, '0,
			Q_MIN, Q_MAX, ALL1), 1'b1, SIDES_BACK});
		directed.push_back('{mk_beat('0, '0, '0, ALL1, 3'd7, '0, '0, '0, '0, '0, '0),
			1'b0, SIDES_NONE});
		// unit normal along x, box straddling, in front, behind
		directed.push_back('{mk_beat(Q_ONE, '0, '0, '0, 3'd0, Q_MONE, '0, '0,
			Q_ONE, '0, '0), 1'b1, SIDES_CROSS});
		directed.push_back('{mk_beat(Q_ONE, '0, '0, '0, 3'd0, Q_ONE, '0, '0,
			Q_TWO, '0, '0), 1'b1, SIDES_FRONT});
		directed.push_back('{mk_beat(Q_ONE, '0, '0, '0, 3'd0, Q_MTWO, '0, '0,
			Q_MONE, '0, '0), 1'b1, SIDES_BACK});
		// inverted box: min above max leaves neither side touched
		directed.push_back('{mk_beat(Q_ONE, '0, '0, '0, 3'd0, Q_ONE, '0, '0,
			Q_MONE, '0, '0), 1'b1, SIDES_NONE});
		// far corner exactly on the plane still counts as front
		directed.push_back('{mk_beat(Q_ONE, '0, '0, Q_ONE, 3'd0, '0, '0, '0,
			Q_ONE, '0, '0), 1'b1, SIDES_CROSS});
		// near corner exactly on the plane is not behind it
		directed.push_back('{mk_beat(Q_ONE, '0, '0, Q_ONE, 3'd0, Q_ONE, '0, '0,
			Q_TWO, '0, '0), 1'b1, SIDES_FRONT});
		// every select code on one mixed-sign plane, consistent or not
		for (s = 0; s < 8; s++)
			directed.push_back('{mk_beat(Q_ONE, Q_MONE, Q_TWO, 32'h0000_8000, 3'(s),
				Q_MTWO, 32'hfffd_0000, Q_MONE, Q_ONE, Q_TWO, 32'h0003_0000),
				1'b0, SIDES_NONE});
		// full-scale operands: the sums run past the signed 64-bit range
		directed.push_back('{mk_beat(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 3'd0, Q_MAX, Q_MAX,
			Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b0, SIDES_NONE});
		directed.push_back('{mk_beat(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 3'd7, Q_MIN, Q_MIN,
			Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0, SIDES_NONE});
		directed.push_back('{mk_beat(Q_MIN, Q_MIN, Q_MIN, '0, 3'd0, Q_MIN, Q_MIN,
			Q_MIN, Q_MAX, Q_MAX, Q_MAX), 1'b0, SIDES_NONE});
		directed.push_back('{mk_beat(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 3'd2, Q_MIN, Q_MIN,
			Q_MIN, Q_MAX, Q_MAX, Q_MAX), 1'b0, SIDES_NONE});
		directed.push_back('{mk_beat(Q_MIN, Q_MIN, Q_MIN, Q_MAX, 3'd7, Q_MIN, Q_MIN,
			Q_MIN, Q_MAX, Q_MAX, Q_MAX), 1'b0, SIDES_NONE});
	endtask

	// Stimulus: reset, directed table, then random beats with the odd full drain.
	initial begin
		int n;
		int gap;
		logic [1:0] sides_exp;
		box_beat_t b;
		fill_directed();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k]) begin
			sides_exp = directed[k].known ? directed[k].sides
				: classify_box(directed[k].beat);
			send_beat(directed[k].beat, sides_exp, $urandom_range(0, 4), 1'b0);
		end
		for (n = 0; n < RANDOM_BEATS; n++) begin
			b = random_beat();
			// every third stretch of 40 beats runs back to back
			gap = ((n / 40) % 3 == 2) ? 0 : $urandom_range(0, 4);
			send_beat(b, classify_box(b), gap, n == 0 || n % 200 == 150);
		end
		s_tvalid <= 1'b0;
		while (sides_q.size() != 0)
			@(posedge clk);
		// let any stray beat out of the pipe before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result side: stall at random, check each accepted beat against the
	// oldest expectation.
	initial begin
		int gap;
		int taken;
		logic [1:0] sides_exp;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = ((taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (!m_tvalid)
				@(negedge clk);
			if (sides_q.size() == 0) begin
				$error("sides: no result expected, got %0d", m_tdata[1:0]);
				mismatches++;
			end else begin
				sides_exp = sides_q.pop_front();
				if (m_tdata[1:0] !== sides_exp) begin
					$error("sides: expected %0d, got %0d", sides_exp, m_tdata[1:0]);
					mismatches++;
				end
			end
			taken++;
			@(posedge clk);
		end
	end

	// Watchdog: count cycles with no beat moving on either side.
	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < STALL_LIMIT) begin
			@(negedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule
